// ===== design/warmup_modified_moving_average_defines.svh =====
// Assertion macros shared by the warmup moving average design.
// Has an include guard; no dependencies.
`ifndef WARMUP_MODIFIED_MOVING_AVERAGE_DEFINES_SVH
`define WARMUP_MODIFIED_MOVING_AVERAGE_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define WMMA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wmma check failed");

// Checks a property at every rising clock edge, reset included.
`define WMMA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("wmma check failed");

`endif

// ===== design/wmma_pkg.sv =====
// Types and constants of the warmup modified moving average block.
// No dependencies.
package wmma_pkg;

   localparam int WINDOW_W     = 11;
   localparam int SAMPLE_W     = 32;
   localparam int SUM_W        = 42;
   localparam int PROD_W       = 44;
   localparam int MAG_W        = 42;
   localparam int DIV_CNT_W    = 6;

   localparam logic [WINDOW_W-1:0]  MAX_WINDOW   = 11'd1024;
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET = 11'd16;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST     = 6'(MAG_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SETUP,
      ST_DIV,
      ST_FINISH
   } wmma_state_type;

endpackage

// ===== design/warmup_modified_moving_average.sv =====
// Per-item averaging over a window: cumulative mean while the window fills,
// then a modified moving average. One shared restoring divider does the work.
// Depends on wmma_pkg and warmup_modified_moving_average_defines.svh.
//
// Each item is a signed Q16.16 sample; each result is the updated average in
// the same format plus a flag that is set once window_size samples have been
// taken. Divisions truncate toward zero. After an item is accepted, the block
// updates the sum or forms the multiply, forms the dividend magnitude, runs
// 42 steps of the radix-2 divider (one quotient bit per cycle over the 42-bit
// magnitude), writes the average back, and returns to idle, where the next item
// can be accepted. The result register lets the next item start while the
// previous result still waits to be taken; that item then holds in its
// write-back cycle until the result register frees. window_size values outside
// 1..1024 are clamped, and a write takes effect from the next item without
// clearing the running state.

`include "warmup_modified_moving_average_defines.svh"

module warmup_modified_moving_average
   import wmma_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic                       rsp_window_full,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [WINDOW_W-1:0]        csr_window_size
);

   wmma_state_type state_ff, state_in;

   logic [WINDOW_W-1:0]        window_size_ff, window_size_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [WINDOW_W-1:0]        win_ff, win_in;
   logic                       fill_ff, fill_in;
   logic signed [SUM_W-1:0]    running_sum_ff, running_sum_in;
   logic [WINDOW_W-1:0]        fill_count_ff, fill_count_in;
   logic signed [SAMPLE_W-1:0] average_ff, average_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       neg_ff, neg_in;
   logic [WINDOW_W-1:0]        rem_ff, rem_in;
   logic [MAG_W-1:0]           quo_ff, quo_in;
   logic [WINDOW_W-1:0]        divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;
   logic                       rsp_window_full_ff, rsp_window_full_in;

   logic                       out_free;
   logic [WINDOW_W-1:0]        eff_win;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   logic [WINDOW_W-1:0]        win_m1;
   logic signed [PROD_W-1:0]   product;
   logic signed [PROD_W-1:0]   num;
   logic [PROD_W-1:0]          num_abs;
   logic [WINDOW_W:0]          trial;
   logic [WINDOW_W:0]          diff;
   logic                       trial_ge;
   logic [SAMPLE_W-1:0]        avg_res;

   // ---------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------
   always_comb begin
      if (window_size_ff == '0) begin
         eff_win = 11'd1;
      end else if (window_size_ff > MAX_WINDOW) begin
         eff_win = MAX_WINDOW;
      end else begin
         eff_win = window_size_ff;
      end

      sum_wide = {running_sum_ff[SUM_W-1], running_sum_ff}
               + {{(SUM_W+1-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      // The two top bits differ only when the sum left the 42-bit range.
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end

      win_m1  = win_ff - 11'd1;
      product = average_ff * $signed({1'b0, win_m1});

      if (fill_ff) begin
         num = {{(PROD_W-SUM_W){running_sum_ff[SUM_W-1]}}, running_sum_ff};
      end else begin
         num = prod_ff + {{(PROD_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      end
      num_abs = num[PROD_W-1] ? (-num) : num;

      trial    = {rem_ff, quo_ff[MAG_W-1]};
      diff     = trial - {1'b0, divisor_ff};
      trial_ge = (trial >= {1'b0, divisor_ff});

      avg_res = neg_ff ? (-quo_ff[SAMPLE_W-1:0]) : quo_ff[SAMPLE_W-1:0];
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: datapath and outputs
   // ---------------------------------------------------------------
   always_comb begin
      window_size_in     = csr_valid ? csr_window_size : window_size_ff;
      sample_in          = sample_ff;
      win_in             = win_ff;
      fill_in            = fill_ff;
      running_sum_in     = running_sum_ff;
      fill_count_in      = fill_count_ff;
      average_in         = average_ff;
      prod_in            = prod_ff;
      neg_in             = neg_ff;
      rem_in             = rem_ff;
      quo_in             = quo_ff;
      divisor_in         = divisor_ff;
      div_cnt_in         = div_cnt_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_average_in     = rsp_average_ff;
      rsp_window_full_in = rsp_window_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               win_in    = eff_win;
               fill_in   = (fill_count_ff < eff_win);
            end
         end
         ST_MUL: begin
            if (fill_ff) begin
               running_sum_in = sum_sat;
               fill_count_in  = fill_count_ff + 11'd1;
            end else begin
               prod_in = product;
            end
         end
         ST_SETUP: begin
            neg_in     = num[PROD_W-1];
            quo_in     = num_abs[MAG_W-1:0];
            rem_in     = '0;
            divisor_in = fill_ff ? fill_count_ff : win_ff;
            div_cnt_in = '0;
         end
         ST_DIV: begin
            rem_in     = trial_ge ? diff[WINDOW_W-1:0] : trial[WINDOW_W-1:0];
            quo_in     = {quo_ff[MAG_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + 6'd1;
         end
         ST_FINISH: begin
            // The quotient registers hold still here, so repeating the
            // write-back while the result register is busy is harmless.
            average_in = avg_res;
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_average_in     = avg_res;
               rsp_window_full_in = (fill_count_ff >= win_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = rsp_average_ff;
   assign rsp_window_full = rsp_window_full_ff;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_size_ff <= WINDOW_RESET;
         running_sum_ff <= '0;
         fill_count_ff  <= '0;
         average_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         running_sum_ff <= running_sum_in;
         fill_count_ff  <= fill_count_in;
         average_ff     <= average_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff          <= sample_in;
      win_ff             <= win_in;
      fill_ff            <= fill_in;
      prod_ff            <= prod_in;
      neg_ff             <= neg_in;
      rem_ff             <= rem_in;
      quo_ff             <= quo_in;
      divisor_ff         <= divisor_in;
      div_cnt_ff         <= div_cnt_in;
      rsp_average_ff     <= rsp_average_in;
      rsp_window_full_ff <= rsp_window_full_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `WMMA_ASSERT(a_accept_starts_work, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_MUL && !req_ready))
   `WMMA_ASSERT(a_div_ends_on_count, clock, reset, (state_ff == ST_DIV && div_cnt_ff == DIV_LAST) |=> (state_ff == ST_FINISH))
   `WMMA_ASSERT(a_fill_bounded, clock, reset, (state_ff == ST_FINISH && fill_ff) |-> (fill_count_ff <= win_ff && fill_count_ff != '0))
   `WMMA_ASSERT(a_result_from_finish, clock, reset, $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for warmup_modified_moving_average: random and directed
// samples, an average predictor in a small class, and random handshake stalls.
// Depends on wmma_pkg and the block's RTL.
module tb_top
   import wmma_pkg::*;
();

   localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic                       window_full;
   } avg_result_type;

   // Tracks the averaging state and holds the results still owed by the block.
   class average_tracker;
      logic [WINDOW_W-1:0] window_reg;
      longint              sum_acc;
      longint              avg_now;
      longint              fill_cnt;
      avg_result_type      owed_q[$];
      int                  errors;

      function new();
         window_reg = WINDOW_RESET;
         sum_acc    = 0;
         avg_now    = 0;
         fill_cnt   = 0;
         errors     = 0;
      endfunction

      function void set_window(logic [WINDOW_W-1:0] w);
         window_reg = w;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] s);
         longint         w;
         longint         x;
         longint         total;
         avg_result_type r;
         w = longint'(window_reg);
         if (w < 1) w = 1;
         if (w > longint'(MAX_WINDOW)) w = longint'(MAX_WINDOW);
         x = s;
         if (fill_cnt < w) begin
            total = sum_acc + x;
            if (total > SUM_HI) total = SUM_HI;
            if (total < SUM_LO) total = SUM_LO;
            sum_acc  = total;
            fill_cnt = fill_cnt + 1;
            avg_now  = sum_acc / fill_cnt;
         end else begin
            avg_now = (avg_now * (w - 1) + x) / w;
         end
         r.average     = avg_now[SAMPLE_W-1:0];
         r.window_full = (fill_cnt >= w);
         owed_q.push_back(r);
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] avg, logic full);
         avg_result_type want;
         if (owed_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("result with no item waiting: avg %0d full %0b", avg, full);
            return;
         end
         want = owed_q.pop_front();
         if (avg !== want.average || full !== want.window_full) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected avg %0d full %0b, got avg %0d full %0b",
                        want.average, want.window_full, avg, full);
         end
      endfunction
   endclass

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic                       rsp_window_full;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic [WINDOW_W-1:0]        csr_window_size = '0;

   average_tracker sb = new();
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int rsp_hold     = 0;

   warmup_modified_moving_average u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average     (rsp_average),
      .rsp_window_full (rsp_window_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check each accepted item, then pick ready for the next cycle.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_average, rsp_window_full);
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9, 0)) inside
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         [2:4]: return $urandom;
         [5:7]: return SAMPLE_W'($urandom_range(1048576, 0)) - 32'sd524288;
         8: return 32'sh7FFFFFFF - SAMPLE_W'($urandom_range(65535, 0));
         default: return 32'sh80000000 + SAMPLE_W'($urandom_range(65535, 0));
      endcase
   endfunction

   // Within this task, valid is only lowered when the sender decides to idle, so back-to-back
   // items keep it high without a second assignment in the same step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99, 0) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_W-1:0] w);
      csr_valid       <= 1'b1;
      csr_window_size <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_window(w);
   endtask

   task automatic run_batch(input logic [WINDOW_W-1:0] w, input int n);
      wait_drained();
      write_window(w);
      repeat (n) send_sample(rand_sample());
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] edge_vals [9];
      edge_vals = '{
         32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF, 32'sh00000001,
         32'sh00010000, 32'shFFFF0000, 32'sh55555555, 32'shAAAAAAAA};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 22;
      rcv_idle_pct = 62;

      // Reset window of 16: field extremes, then fill the window and move on.
      foreach (edge_vals[i]) send_sample(edge_vals[i]);
      repeat (12) send_sample(rand_sample());
      // Zero acts as a window of one, already below the fill count.
      run_batch(11'd0, 5);

      // Window grown after filling, with a long receiver hold so the block backs up.
      wait_drained();
      write_window(11'd24);
      rsp_hold = 400;
      repeat (60) send_sample(rand_sample());
      wait_drained();
      repeat (40) send_sample(rand_sample());
      run_batch(11'd1, 40);

      snd_idle_pct = 62;
      rcv_idle_pct = 22;
      run_batch(MAX_WINDOW, 100);
      run_batch(11'd2, 30);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      // Out-of-range window clamps to the maximum; then shrink to a mid size.
      run_batch(11'd2047, 60);
      run_batch(11'd130, 40);

      wait_drained();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
